// File: rtl/core/assert_macros.svh
// assertion macros used by the rtl top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: rtl/core/pvi_pkg.sv
// types and constants of the variable-integral pid controller
`timescale 1ns / 1ps
package pvi_pkg;
    localparam int VALUE_WIDTH     = 32;
    localparam int FRACTION_BITS   = 16;
    localparam int SUM_WIDTH       = 48;
    localparam int GAIN_WIDTH      = 16;
    localparam int GAIN_FRAC       = 12;
    localparam int WEIGHT_WIDTH    = 8;
    localparam int BAND_WIDTH      = 31;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int ACC_WIDTH       = SUM_WIDTH + GAIN_WIDTH;
    localparam int DIV_WIDTH       = VALUE_WIDTH + WEIGHT_WIDTH + 1;
    localparam int CNT_WIDTH       = $clog2(GAIN_WIDTH);
    localparam int GRADE_STEP      = 20;
    localparam int BAND_DEFAULT    = 180;

    localparam logic [DIV_WIDTH-1:0] GRADE_DIVISOR =
        DIV_WIDTH'(GRADE_STEP) << FRACTION_BITS;
    localparam logic [DIV_WIDTH-1:0] GRADE_CAP_LIMIT = GRADE_DIVISOR << WEIGHT_WIDTH;
    localparam logic [CNT_WIDTH-1:0] MUL_LAST    = CNT_WIDTH'(GAIN_WIDTH - 1);
    localparam logic [CNT_WIDTH-1:0] WEIGHT_LAST = CNT_WIDTH'(WEIGHT_WIDTH - 1);

    localparam logic [GAIN_WIDTH-1:0] GAIN_P_RESET = GAIN_WIDTH'(1638);
    localparam logic [GAIN_WIDTH-1:0] GAIN_I_RESET = GAIN_WIDTH'(819);
    localparam logic [GAIN_WIDTH-1:0] GAIN_D_RESET = GAIN_WIDTH'(819);
    localparam logic [BAND_WIDTH-1:0] BAND_RESET   =
        BAND_WIDTH'(BAND_DEFAULT) << FRACTION_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_CLASS, ST_DIV,
        ST_MUL_P, ST_MUL_D, ST_MUL_I, ST_MUL_W, ST_DONE
    } state_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_BAND
    } cfg_index_t;
endpackage

// File: rtl/core/pid_variable_integral_top.sv
// Positional pid controller with variable-speed integration. Each accepted
// setpoint request yields one result: the Q16.16 drive and the integral weight.
// One shift-add multiplier retires one gain bit per cycle for Kp, Kd and Ki
// and one weight bit per cycle for the weight product; when the weight falls in
// the graded band, it comes first from a restoring divider that yields one
// quotient bit per cycle. A new request is taken once the previous one has
// left the datapath; the finished result waits in an output register.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pid_variable_integral_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pvi_pkg::VALUE_WIDTH-1:0] s_setpoint,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pvi_pkg::VALUE_WIDTH-1:0] m_drive,
    output logic [pvi_pkg::WEIGHT_WIDTH-1:0]     m_integral_weight,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pvi_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [pvi_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    localparam int VW = pvi_pkg::VALUE_WIDTH;
    localparam int SW = pvi_pkg::SUM_WIDTH;
    localparam int AW = pvi_pkg::ACC_WIDTH;
    localparam int DW = pvi_pkg::DIV_WIDTH;
    localparam int GW = pvi_pkg::GAIN_WIDTH;
    localparam int WW = pvi_pkg::WEIGHT_WIDTH;
    localparam int CW = pvi_pkg::CNT_WIDTH;
    localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    pvi_pkg::state_t state_reg, state_next;

    logic signed [VW-1:0] sp_reg, sp_next;
    logic signed [VW-1:0] err_reg, err_next;
    logic signed [VW-1:0] prev_out_reg, prev_out_next;
    logic signed [VW-1:0] prev_err_reg, prev_err_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [GW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [pvi_pkg::BAND_WIDTH-1:0] band_reg;
    logic [WW-1:0] weight_reg, weight_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] divisor_reg, divisor_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] mc_reg, mc_next;
    logic signed [AW-1:0] pd_reg, pd_next;
    logic [GW-1:0] mp_reg, mp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [VW-1:0] out_drive_reg, out_drive_next;
    logic [WW-1:0] out_weight_reg, out_weight_next;
    logic out_valid_reg, out_valid_next;

    // error against the fed-back output, saturated
    logic signed [VW:0] err_wide;
    logic signed [VW-1:0] err_sat;
    assign err_wide = {sp_reg[VW-1], sp_reg} - {prev_out_reg[VW-1], prev_out_reg};
    assign err_sat  = (err_wide[VW] != err_wide[VW-1]) ? (err_wide[VW] ? V_MIN : V_MAX)
                                                       : err_wide[VW-1:0];

    // magnitude, weight class and integral update
    logic [VW:0] aerr_wide;
    logic [VW-1:0] aerr;
    logic freeze, in_band;
    logic [DW-1:0] gap;
    logic signed [SW:0] sum_wide;
    logic signed [SW-1:0] sum_sat;
    assign aerr_wide = err_reg[VW-1] ? ((VW+1)'(0) - {err_reg[VW-1], err_reg})
                                     : {1'b0, err_reg};
    assign aerr    = aerr_wide[VW-1:0];
    assign freeze  = sp_reg[VW-1] || (aerr > sp_reg[VW-1:0]);
    assign in_band = DW'(aerr) < DW'(band_reg);
    assign gap     = DW'(sp_reg[VW-1:0]) - DW'(aerr);
    assign sum_wide = {sum_reg[SW-1], sum_reg} + (SW+1)'(err_reg);
    assign sum_sat  = (sum_wide[SW] != sum_wide[SW-1]) ? (sum_wide[SW] ? S_MIN : S_MAX)
                                                       : sum_wide[SW-1:0];

    // derivative operand
    logic signed [VW:0] derr;
    assign derr = {err_reg[VW-1], err_reg} - {prev_err_reg[VW-1], prev_err_reg};

    // shift-add step, top gain bit carries negative weight
    logic neg_step;
    logic signed [AW-1:0] addend, acc_step, acc_shift;
    assign neg_step = (state_reg != pvi_pkg::ST_MUL_W) && (cnt_reg == pvi_pkg::MUL_LAST);
    assign addend   = mp_reg[0] ? (neg_step ? -mc_reg : mc_reg) : '0;
    assign acc_step = acc_reg + addend;
    assign acc_shift = acc_step >>> pvi_pkg::GAIN_FRAC;

    // restoring division step
    logic div_fit;
    assign div_fit = rem_reg >= divisor_reg;

    // output total, saturated
    logic signed [AW-1:0] total;
    logic signed [VW-1:0] total_sat;
    logic total_ovf;
    assign total     = pd_reg + acc_reg;
    assign total_ovf = (total[AW-1:VW-1] != {(AW-VW+1){1'b0}})
                    && (total[AW-1:VW-1] != {(AW-VW+1){1'b1}});
    assign total_sat = total_ovf ? (total[AW-1] ? V_MIN : V_MAX) : total[VW-1:0];

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready   = (state_reg == pvi_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_drive   = out_drive_reg;
    assign m_integral_weight = out_weight_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pvi_pkg::ST_IDLE: begin
                if (s_valid) state_next = pvi_pkg::ST_ERR;
            end
            pvi_pkg::ST_ERR: state_next = pvi_pkg::ST_CLASS;
            pvi_pkg::ST_CLASS: begin
                if (!freeze && !in_band && gap < pvi_pkg::GRADE_CAP_LIMIT) begin
                    state_next = pvi_pkg::ST_DIV;
                end else begin
                    state_next = pvi_pkg::ST_MUL_P;
                end
            end
            pvi_pkg::ST_DIV: begin
                if (cnt_reg == pvi_pkg::WEIGHT_LAST) state_next = pvi_pkg::ST_MUL_P;
            end
            pvi_pkg::ST_MUL_P: begin
                if (cnt_reg == pvi_pkg::MUL_LAST) state_next = pvi_pkg::ST_MUL_D;
            end
            pvi_pkg::ST_MUL_D: begin
                if (cnt_reg == pvi_pkg::MUL_LAST) state_next = pvi_pkg::ST_MUL_I;
            end
            pvi_pkg::ST_MUL_I: begin
                if (cnt_reg == pvi_pkg::MUL_LAST) state_next = pvi_pkg::ST_MUL_W;
            end
            pvi_pkg::ST_MUL_W: begin
                if (cnt_reg == pvi_pkg::WEIGHT_LAST) state_next = pvi_pkg::ST_DONE;
            end
            pvi_pkg::ST_DONE: begin
                if (out_free) state_next = pvi_pkg::ST_IDLE;
            end
            default: state_next = pvi_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        sp_next         = sp_reg;
        err_next        = err_reg;
        prev_out_next   = prev_out_reg;
        prev_err_next   = prev_err_reg;
        sum_next        = sum_reg;
        weight_next     = weight_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        acc_next        = acc_reg;
        mc_next         = mc_reg;
        pd_next         = pd_reg;
        mp_next         = mp_reg;
        cnt_next        = cnt_reg;
        out_drive_next  = out_drive_reg;
        out_weight_next = out_weight_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        case (state_reg)
            pvi_pkg::ST_IDLE: begin
                if (s_valid) sp_next = s_setpoint;
            end
            pvi_pkg::ST_ERR: err_next = err_sat;
            pvi_pkg::ST_CLASS: begin
                if (!freeze) sum_next = sum_sat;
                cnt_next     = '0;
                rem_next     = gap;
                divisor_next = pvi_pkg::GRADE_DIVISOR << (WW - 1);
                acc_next     = '0;
                mc_next      = AW'(err_reg);
                mp_next      = gain_p_reg;
                if (freeze) begin
                    weight_next = '0;
                end else if (in_band) begin
                    weight_next = WW'(1);
                end else if (gap >= pvi_pkg::GRADE_CAP_LIMIT) begin
                    weight_next = '1;
                end else begin
                    weight_next = '0;
                end
            end
            pvi_pkg::ST_DIV: begin
                weight_next  = {weight_reg[WW-2:0], div_fit};
                if (div_fit) rem_next = rem_reg - divisor_reg;
                divisor_next = divisor_reg >> 1;
                cnt_next     = (cnt_reg == pvi_pkg::WEIGHT_LAST) ? '0 : cnt_reg + CW'(1);
            end
            pvi_pkg::ST_MUL_P, pvi_pkg::ST_MUL_D, pvi_pkg::ST_MUL_I,
            pvi_pkg::ST_MUL_W: begin
                acc_next = acc_step;
                mc_next  = mc_reg <<< 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg + CW'(1);
                if (state_reg == pvi_pkg::ST_MUL_P && cnt_reg == pvi_pkg::MUL_LAST) begin
                    mc_next  = AW'(derr);
                    mp_next  = gain_d_reg;
                    cnt_next = '0;
                end
                if (state_reg == pvi_pkg::ST_MUL_D && cnt_reg == pvi_pkg::MUL_LAST) begin
                    pd_next  = acc_shift;
                    acc_next = '0;
                    mc_next  = AW'(sum_reg);
                    mp_next  = gain_i_reg;
                    cnt_next = '0;
                end
                if (state_reg == pvi_pkg::ST_MUL_I && cnt_reg == pvi_pkg::MUL_LAST) begin
                    acc_next = '0;
                    mc_next  = acc_shift;
                    mp_next  = GW'(weight_reg);
                    cnt_next = '0;
                end
            end
            pvi_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_drive_next  = total_sat;
                    out_weight_next = weight_reg;
                    prev_out_next   = total_sat;
                    prev_err_next   = err_reg;
                end
            end
            default: ;
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pvi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_out_reg  <= '0;
            prev_err_reg  <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            gain_p_reg    <= pvi_pkg::GAIN_P_RESET;
            gain_i_reg    <= pvi_pkg::GAIN_I_RESET;
            gain_d_reg    <= pvi_pkg::GAIN_D_RESET;
            band_reg      <= pvi_pkg::BAND_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_out_reg  <= prev_out_next;
            prev_err_reg  <= prev_err_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            if (cfg_valid) begin
                case (pvi_pkg::cfg_index_t'(cfg_index))
                    pvi_pkg::CFG_GAIN_P: gain_p_reg <= cfg_data[GW-1:0];
                    pvi_pkg::CFG_GAIN_I: gain_i_reg <= cfg_data[GW-1:0];
                    pvi_pkg::CFG_GAIN_D: gain_d_reg <= cfg_data[GW-1:0];
                    pvi_pkg::CFG_BAND:   band_reg <= cfg_data[pvi_pkg::BAND_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sp_reg         <= sp_next;
        err_reg        <= err_next;
        weight_reg     <= weight_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        acc_reg        <= acc_next;
        mc_reg         <= mc_next;
        pd_reg         <= pd_next;
        mp_reg         <= mp_next;
        out_drive_reg  <= out_drive_next;
        out_weight_reg <= out_weight_next;
    end

    // an accepted request starts the error stage
    `ASSERT_CLK(a_accept_starts, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == pvi_pkg::ST_ERR))
    // a frozen integral keeps its sum
    `ASSERT_CLK(a_freeze_holds, aclk, aresetn, (state_reg == pvi_pkg::ST_CLASS && freeze) |=> (sum_reg == $past(sum_reg)))
    // a result appears only from the final stage
    `ASSERT_CLK(a_result_from_done, aclk, aresetn, $rose(out_valid_reg) |-> ($past(state_reg) == pvi_pkg::ST_DONE))
endmodule

// File: tb/sv/pid_variable_integral_top_test.sv
// testbench for the variable-integral pid controller: scoreboard, drivers and checks
`timescale 1ns / 1ps
module pid_variable_integral_top_test;

    localparam longint RUN_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic signed [pvi_pkg::VALUE_WIDTH-1:0] drive;
        logic [pvi_pkg::WEIGHT_WIDTH-1:0]       weight;
    } pid_result_t;

    // tracks the controller state and holds the drives still to come
    class pid_scoreboard;
        longint kp, ki, kd, band;
        longint last_drive, last_err, err_sum;
        pid_result_t pending_q[$];
        int errors;
        int checked;
        int graded_seen;
        int frozen_seen;

        function new();
            kp = 1638;
            ki = 819;
            kd = 819;
            band = longint'(pvi_pkg::BAND_RESET);
            last_drive = 0;
            last_err = 0;
            err_sum = 0;
            errors = 0;
            checked = 0;
            graded_seen = 0;
            frozen_seen = 0;
        endfunction

        function longint clamp(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function void write_reg(pvi_pkg::cfg_index_t idx,
                                logic [pvi_pkg::CFG_DATA_WIDTH-1:0] d);
            case (idx)
                pvi_pkg::CFG_GAIN_P: kp = longint'($signed(d[pvi_pkg::GAIN_WIDTH-1:0]));
                pvi_pkg::CFG_GAIN_I: ki = longint'($signed(d[pvi_pkg::GAIN_WIDTH-1:0]));
                pvi_pkg::CFG_GAIN_D: kd = longint'($signed(d[pvi_pkg::GAIN_WIDTH-1:0]));
                pvi_pkg::CFG_BAND:   band = longint'({1'b0, d[pvi_pkg::BAND_WIDTH-1:0]});
                default: ;
            endcase
        endfunction

        // one control step; products here stay well inside 64 bits
        function void note_setpoint(logic signed [pvi_pkg::VALUE_WIDTH-1:0] sp_in);
            longint sp, err, aerr, w, pd, iterm, total;
            pid_result_t r;
            sp = longint'(sp_in);
            err = clamp(sp - last_drive, pvi_pkg::VALUE_WIDTH);
            aerr = (err < 0) ? -err : err;
            if (aerr > sp) begin
                w = 0;
                frozen_seen++;
            end else begin
                if (aerr < band) begin
                    w = 1;
                end else begin
                    w = (sp - aerr) / (longint'(pvi_pkg::GRADE_STEP) <<< pvi_pkg::FRACTION_BITS);
                    if (w > 255) w = 255;
                    graded_seen++;
                end
                err_sum = clamp(err_sum + err, pvi_pkg::SUM_WIDTH);
            end
            pd = kp * err + kd * (err - last_err);
            iterm = ((ki * err_sum) >>> pvi_pkg::GAIN_FRAC) * w;
            total = clamp((pd >>> pvi_pkg::GAIN_FRAC) + iterm, pvi_pkg::VALUE_WIDTH);
            last_err = err;
            last_drive = total;
            r.drive = total[pvi_pkg::VALUE_WIDTH-1:0];
            r.weight = w[pvi_pkg::WEIGHT_WIDTH-1:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [pvi_pkg::VALUE_WIDTH-1:0] drive,
                                   logic [pvi_pkg::WEIGHT_WIDTH-1:0] weight);
            pid_result_t r;
            if (pending_q.size() == 0) begin
                $error("result with no request pending: drive %0d weight %0d",
                       drive, weight);
                errors++;
                return;
            end
            r = pending_q.pop_front();
            checked++;
            if (drive !== r.drive) begin
                $error("drive: expected %0d actual %0d", r.drive, drive);
                errors++;
            end
            if (weight !== r.weight) begin
                $error("integral_weight: expected %0d actual %0d", r.weight, weight);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [pvi_pkg::VALUE_WIDTH-1:0] s_setpoint;
    logic m_valid;
    logic m_ready;
    logic signed [pvi_pkg::VALUE_WIDTH-1:0] m_drive;
    logic [pvi_pkg::WEIGHT_WIDTH-1:0] m_integral_weight;
    logic cfg_valid;
    logic cfg_ready;
    logic [pvi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [pvi_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

    pid_scoreboard sb;
    longint cycles;
    int setpoint_count;
    int cfg_count;
    bit calm;

    pid_variable_integral_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_setpoint(s_setpoint),
        .m_valid(m_valid), .m_ready(m_ready), .m_drive(m_drive),
        .m_integral_weight(m_integral_weight),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // monitors and run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_setpoint(s_setpoint);
                setpoint_count <= setpoint_count + 1;
            end
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(pvi_pkg::cfg_index_t'(cfg_index), cfg_data);
                cfg_count <= cfg_count + 1;
            end
            if (m_valid && m_ready)
                sb.check_result(m_drive, m_integral_weight);
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 27);
    end

    task automatic write_cfg(pvi_pkg::cfg_index_t idx,
                             logic [pvi_pkg::CFG_DATA_WIDTH-1:0] d);
        int start;
        @(negedge aclk);
        start = cfg_count;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(negedge aclk); while (cfg_count == start);
        cfg_valid = 1'b0;
    endtask

    task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                           logic [30:0] band);
        write_cfg(pvi_pkg::CFG_GAIN_P, {16'h0, p});
        write_cfg(pvi_pkg::CFG_GAIN_I, {16'h0, i});
        write_cfg(pvi_pkg::CFG_GAIN_D, {16'h0, d});
        write_cfg(pvi_pkg::CFG_BAND, {1'b0, band});
    endtask

    // called at a falling edge; leaves valid high until the request is taken
    task automatic send_setpoint(logic signed [pvi_pkg::VALUE_WIDTH-1:0] sp);
        int start;
        while (!calm && $urandom_range(99) < 27) begin
            s_valid = 1'b0;
            s_setpoint = $urandom;
            @(negedge aclk);
        end
        start = setpoint_count;
        s_valid = 1'b1;
        s_setpoint = sp;
        do @(negedge aclk); while (setpoint_count == start);
        s_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [pvi_pkg::VALUE_WIDTH-1:0] pick_setpoint();
        int kind;
        kind = $urandom_range(9);
        if (kind < 2) return $urandom;
        if (kind < 4) return $signed($urandom_range(400 << 16)) - (200 << 16);
        if (kind < 5)
            return pvi_pkg::VALUE_WIDTH'(-$signed({1'b0, $urandom_range(32'h7fff_ffff)}));
        // large positive targets steer the error into the graded band
        return pvi_pkg::VALUE_WIDTH'(
            $signed({1'b0, $urandom_range(32'h7fff_ffff, 32'h0100_0000)}));
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_setpoint(pick_setpoint());
    endtask

    initial begin
        sb = new();
        cycles = 0;
        setpoint_count = 0;
        cfg_count = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_setpoint = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, weight one, graded band, frozen integral
        send_setpoint(32'sh7fff_ffff);
        send_setpoint(32'sh8000_0000);
        send_setpoint(32'sh7fff_ffff);
        send_setpoint(32'sh7fff_ffff);
        send_setpoint(0);
        send_setpoint(1);
        send_setpoint(-1);
        send_setpoint(5 <<< 16);
        send_setpoint(5 <<< 16);
        send_setpoint(-(50 <<< 16));
        repeat (6) send_setpoint(1000 <<< 16);
        repeat (4) send_setpoint(32'sh4000_0000);
        send_setpoint(32'sh8000_0000);
        drain();

        // default registers, then sweeps through extreme settings
        random_phase(300);
        drain();
        set_all(16'h7fff, 16'h7fff, 16'h7fff, 31'h0);
        random_phase(250);
        drain();
        set_all(16'h8000, 16'h8000, 16'h8000, 31'h7fff_ffff);
        random_phase(250);
        drain();
        set_all(16'h0, 16'h0, 16'h0, 31'h0000_0001);
        random_phase(100);
        drain();
        // no idling on either side for a while
        set_all(16'd1638, 16'd819, 16'd819, 31'(pvi_pkg::BAND_RESET));
        calm = 1'b1;
        random_phase(300);
        calm = 1'b0;
        drain();
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 31'($urandom));
        random_phase(200);
        drain();
        set_all(16'd4096, 16'd4096, 16'h0, 31'(1 << 20));
        // sender holds off until each drive is back
        repeat (100) begin
            send_setpoint(pick_setpoint());
            while (sb.pending_q.size() != 0) @(negedge aclk);
        end
        set_all(16'($urandom), 16'($urandom), 16'($urandom),
                31'($urandom_range(32'h00ff_ffff)));
        random_phase(380);
        drain();

        $display("checked %0d drives over %0d setpoints, %0d register writes",
                 sb.checked, setpoint_count, cfg_count);
        $display("graded-band steps %0d, frozen-integral steps %0d",
                 sb.graded_seen, sb.frozen_seen);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pvi_pkg.sv
rtl/core/pid_variable_integral_top.sv
tb/sv/pid_variable_integral_top_test.sv
